// File: rtl/svalu_pkg.sv
// ----------------------------------------------------------------------------
// svalu_pkg
// Shared types, widths and helpers for the Q16.16 vector ALU.
// ----------------------------------------------------------------------------
package svalu_pkg;

  localparam int LANES          = 4;
  localparam int MAX_COMPONENTS = 4;
  localparam int CNT_W          = 3;
  localparam int CMD_W          = 3;
  localparam int DATA_W         = 32;
  localparam int FRAC_W         = 16;
  localparam int XW             = DATA_W + 1;
  localparam int PROD_W         = 65;
  localparam int SUM_W          = 67;
  localparam int SAT_W          = SUM_W;
  localparam int RAD_W          = 66;
  localparam int ROOT_W         = 33;
  localparam int REM_W          = 36;
  localparam int SQ_STAGES      = ROOT_W;
  localparam int Q_W            = 17;
  localparam int DIV_STAGES     = Q_W;
  localparam int DVD_W          = 50;
  localparam int FRONT_STAGES   = 4;
  localparam int LINE_STAGES    = SQ_STAGES + DIV_STAGES;
  localparam int TOT_STAGES     = FRONT_STAGES + LINE_STAGES;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_SCALE = 3'd2,
    CMD_LERP  = 3'd3,
    CMD_DOT   = 3'd4,
    CMD_MAGSQ = 3'd5,
    CMD_MAG   = 3'd6,
    CMD_NORM  = 3'd7
  } cmd_e;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef word_t [LANES-1:0] vec_t;

  localparam word_t WORD_MAX = 32'sh7fff_ffff;
  localparam word_t WORD_MIN = 32'sh8000_0000;

  localparam logic signed [PROD_W-1:0] PROD_HALF = 65'sh8000;
  localparam logic signed [SUM_W-1:0]  SUM_HALF  = 67'sh8000;
  localparam logic signed [SAT_W-1:0]  SAT_HI    = SAT_W'(WORD_MAX);
  localparam logic signed [SAT_W-1:0]  SAT_LO    = SAT_W'(WORD_MIN);

  typedef struct packed {
    logic  flag;
    word_t val;
  } sat_t;

  typedef sat_t lane_res_t;

  typedef struct packed {
    cmd_e  cmd;
    logic  rsat;
    vec_t  r;
    logic  dsat;
    word_t dsc;
    vec_t  a;
  } side_t;

  typedef struct packed {
    vec_t  v;
    word_t sc;
    logic  flag;
  } out_t;

  function automatic sat_t sat32(input logic signed [SAT_W-1:0] v);
    sat_t r;
    r.flag = 1'b0;
    r.val  = v[DATA_W-1:0];
    if (v > SAT_HI) begin
      r.flag = 1'b1;
      r.val  = WORD_MAX;
    end else if (v < SAT_LO) begin
      r.flag = 1'b1;
      r.val  = WORD_MIN;
    end
    return r;
  endfunction

endpackage

// File: rtl/svalu_if.sv
// ----------------------------------------------------------------------------
// svalu_if
// Valid/ready channels for command beats in and result beats out.
// ----------------------------------------------------------------------------
interface svalu_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [2:0]  component_count;
  logic signed [31:0] a_0;
  logic signed [31:0] a_1;
  logic signed [31:0] a_2;
  logic signed [31:0] a_3;
  logic signed [31:0] b_0;
  logic signed [31:0] b_1;
  logic signed [31:0] b_2;
  logic signed [31:0] b_3;
  logic signed [31:0] scalar_in;

  modport source (
    output valid, command, component_count, a_0, a_1, a_2, a_3,
           b_0, b_1, b_2, b_3, scalar_in,
    input  ready
  );
  modport sink (
    input  valid, command, component_count, a_0, a_1, a_2, a_3,
           b_0, b_1, b_2, b_3, scalar_in,
    output ready
  );
endinterface

interface svalu_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] out_0;
  logic signed [31:0] out_1;
  logic signed [31:0] out_2;
  logic signed [31:0] out_3;
  logic signed [31:0] scalar_out;
  logic        saturated;

  modport source (
    output valid, out_0, out_1, out_2, out_3, scalar_out, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_0, out_1, out_2, out_3, scalar_out, saturated,
    output ready
  );
endinterface

// File: rtl/small_vector_alu.sv
// ----------------------------------------------------------------------------
// small_vector_alu
// Four-lane Q16.16 vector ALU: add, sub, scale, lerp, dot, squared
// magnitude, magnitude and normalize, with saturation.
//
//   channel | dir | beat
//   --------+-----+----------------------------------------------
//   in_i    | in  | command, count, vectors a and b, scalar
//   out_o   | out | result vector, scalar, saturated flag
//
// One beat per cycle while the result queue has room; every command passes
// through 4 lane/merge stages, 33 square root stages (one root bit each)
// and 17 divider stages (one quotient bit each), then the queue.
// The whole pipeline advances together and stops only when the two-entry
// result queue is full. Reset clears the stage valid bits and the queue.
// ----------------------------------------------------------------------------
module small_vector_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  svalu_in_if.sink    in_i,
  svalu_out_if.source out_o
);

  logic en, full, accept, push;
  logic [svalu_pkg::CNT_W-1:0] n;
  svalu_pkg::cmd_e  cmd_in;
  svalu_pkg::word_t a_raw [svalu_pkg::LANES];
  svalu_pkg::word_t b_raw [svalu_pkg::LANES];
  svalu_pkg::word_t a_in  [svalu_pkg::LANES];
  svalu_pkg::word_t b_in  [svalu_pkg::LANES];

  logic signed [svalu_pkg::PROD_W-1:0] prod [svalu_pkg::LANES];
  svalu_pkg::lane_res_t                lres [svalu_pkg::LANES];

  logic [svalu_pkg::TOT_STAGES-1:0] vld_q;
  svalu_pkg::cmd_e cmd_f_q [svalu_pkg::FRONT_STAGES];
  svalu_pkg::vec_t a_f_q   [svalu_pkg::FRONT_STAGES];
  logic signed [svalu_pkg::SUM_W-1:0] s01_q, s23_q, tot_q, drnd;
  svalu_pkg::vec_t r4_q;
  logic            rsat4_q;
  svalu_pkg::sat_t dres;
  svalu_pkg::side_t side_in;
  svalu_pkg::side_t side_q [svalu_pkg::LINE_STAGES];
  logic [svalu_pkg::ROOT_W-1:0] root;
  logic [svalu_pkg::ROOT_W-1:0] m_div [svalu_pkg::LANES];
  svalu_pkg::word_t             q_div [svalu_pkg::LANES];
  svalu_pkg::side_t sd;
  svalu_pkg::sat_t  msat;
  svalu_pkg::out_t  fin;

  assign en         = !full;
  assign in_i.ready = en;
  assign accept     = in_i.valid && en;
  assign cmd_in     = svalu_pkg::cmd_e'(in_i.command);

  always_comb begin
    a_raw[0] = in_i.a_0;  a_raw[1] = in_i.a_1;
    a_raw[2] = in_i.a_2;  a_raw[3] = in_i.a_3;
    b_raw[0] = in_i.b_0;  b_raw[1] = in_i.b_1;
    b_raw[2] = in_i.b_2;  b_raw[3] = in_i.b_3;
    n = (in_i.component_count > svalu_pkg::CNT_W'(svalu_pkg::MAX_COMPONENTS))
      ? svalu_pkg::CNT_W'(svalu_pkg::MAX_COMPONENTS) : in_i.component_count;
    for (int i = 0; i < svalu_pkg::LANES; i++) begin
      a_in[i] = (svalu_pkg::CNT_W'(i) < n) ? a_raw[i] : '0;
      b_in[i] = (svalu_pkg::CNT_W'(i) < n) ? b_raw[i] : '0;
    end
  end

  for (genvar i = 0; i < svalu_pkg::LANES; i++) begin : g_lane
    svalu_lane u_lane (
      .clk_i  (clk_i),
      .en_i   (en),
      .cmd_i  (cmd_in),
      .a_i    (a_in[i]),
      .b_i    (b_in[i]),
      .s_i    (in_i.scalar_in),
      .prod_o (prod[i]),
      .res_o  (lres[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[svalu_pkg::TOT_STAGES-2:0], accept};
    end
  end

  // front stages and product merge
  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd_f_q[0] <= cmd_in;
      for (int i = 0; i < svalu_pkg::LANES; i++) a_f_q[0][i] <= a_in[i];
      for (int k = 1; k < svalu_pkg::FRONT_STAGES; k++) begin
        cmd_f_q[k] <= cmd_f_q[k-1];
        a_f_q[k]   <= a_f_q[k-1];
      end
      s01_q   <= svalu_pkg::SUM_W'(prod[0]) + svalu_pkg::SUM_W'(prod[1]);
      s23_q   <= svalu_pkg::SUM_W'(prod[2]) + svalu_pkg::SUM_W'(prod[3]);
      tot_q   <= s01_q + s23_q;
      rsat4_q <= lres[0].flag | lres[1].flag | lres[2].flag | lres[3].flag;
      for (int i = 0; i < svalu_pkg::LANES; i++) r4_q[i] <= lres[i].val;
    end
  end

  assign drnd = (tot_q + svalu_pkg::SUM_HALF) >>> svalu_pkg::FRAC_W;
  assign dres = svalu_pkg::sat32(drnd);

  always_comb begin
    side_in.cmd  = cmd_f_q[svalu_pkg::FRONT_STAGES-1];
    side_in.rsat = rsat4_q;
    side_in.r    = r4_q;
    side_in.dsat = dres.flag;
    side_in.dsc  = dres.val;
    side_in.a    = a_f_q[svalu_pkg::FRONT_STAGES-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_in;
      for (int k = 1; k < svalu_pkg::LINE_STAGES; k++) side_q[k] <= side_q[k-1];
    end
  end

  // sum of squares is never negative for the magnitude commands
  svalu_isqrt u_isqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (svalu_pkg::RAD_W'(tot_q[svalu_pkg::RAD_W-2:0])),
    .root_o (root)
  );

  for (genvar i = 0; i < svalu_pkg::LANES; i++) begin : g_div
    svalu_div u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (side_q[svalu_pkg::SQ_STAGES-1].a[i]),
      .m_i   (root),
      .q_o   (q_div[i]),
      .m_o   (m_div[i])
    );
  end

  assign sd   = side_q[svalu_pkg::LINE_STAGES-1];
  assign msat = svalu_pkg::sat32(svalu_pkg::SAT_W'(signed'({1'b0, m_div[0]})));

  always_comb begin
    fin = '0;
    case (sd.cmd)
      svalu_pkg::CMD_ADD,
      svalu_pkg::CMD_SUB,
      svalu_pkg::CMD_SCALE,
      svalu_pkg::CMD_LERP: begin
        fin.v    = sd.r;
        fin.flag = sd.rsat;
      end
      svalu_pkg::CMD_DOT,
      svalu_pkg::CMD_MAGSQ: begin
        fin.sc   = sd.dsc;
        fin.flag = sd.dsat;
      end
      svalu_pkg::CMD_MAG: begin
        fin.sc   = msat.val;
        fin.flag = msat.flag;
      end
      svalu_pkg::CMD_NORM: begin
        // zero vector comes back as zero
        if (m_div[0] != '0) begin
          for (int i = 0; i < svalu_pkg::LANES; i++) fin.v[i] = q_div[i];
        end
        fin.sc   = msat.val;
        fin.flag = msat.flag;
      end
      default: fin = '0;
    endcase
  end

  assign push = en && vld_q[svalu_pkg::TOT_STAGES-1];

  svalu_outq u_outq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (fin),
    .full_o (full),
    .out_o  (out_o)
  );

`ifndef SYNTHESIS
  // a clipped result always shows a bound somewhere in the beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.saturated |->
      out_o.scalar_out == svalu_pkg::WORD_MAX || out_o.scalar_out == svalu_pkg::WORD_MIN ||
      out_o.out_0 == svalu_pkg::WORD_MAX || out_o.out_0 == svalu_pkg::WORD_MIN ||
      out_o.out_1 == svalu_pkg::WORD_MAX || out_o.out_1 == svalu_pkg::WORD_MIN ||
      out_o.out_2 == svalu_pkg::WORD_MAX || out_o.out_2 == svalu_pkg::WORD_MIN ||
      out_o.out_3 == svalu_pkg::WORD_MAX || out_o.out_3 == svalu_pkg::WORD_MIN)
    else $error("saturated beat without a clipped field");

  // the queue must never be written while full
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[svalu_pkg::TOT_STAGES-1] && full |=> $stable(vld_q))
    else $error("pipeline moved while result queue full");

  // a full queue always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> out_o.valid && !in_i.ready)
    else $error("full queue without valid result");
`endif

endmodule

// File: rtl/svalu_lane.sv
// ----------------------------------------------------------------------------
// svalu_lane
// One component lane: operand select, multiply, round and saturate.
// ----------------------------------------------------------------------------
module svalu_lane (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  svalu_pkg::cmd_e             cmd_i,
  input  svalu_pkg::word_t            a_i,
  input  svalu_pkg::word_t            b_i,
  input  svalu_pkg::word_t            s_i,
  output logic signed [svalu_pkg::PROD_W-1:0] prod_o,
  output svalu_pkg::lane_res_t        res_o
);

  logic signed [svalu_pkg::XW-1:0]     x_d, x_q, sum_d, sum1_q, sum2_q;
  svalu_pkg::word_t                    y_d, y_q, a1_q, a2_q;
  svalu_pkg::cmd_e                     cmd1_q, cmd2_q;
  logic signed [svalu_pkg::PROD_W-1:0] prod_q, rnd;
  svalu_pkg::lane_res_t                res_d, res_q;

  always_comb begin
    // lerp multiplies the difference, everything else multiplies a
    x_d = (cmd_i == svalu_pkg::CMD_LERP) ? svalu_pkg::XW'(b_i) - svalu_pkg::XW'(a_i)
                                         : svalu_pkg::XW'(a_i);
    case (cmd_i)
      svalu_pkg::CMD_DOT:   y_d = b_i;
      svalu_pkg::CMD_SCALE: y_d = s_i;
      svalu_pkg::CMD_LERP:  y_d = s_i;
      default:              y_d = a_i;
    endcase
    sum_d = (cmd_i == svalu_pkg::CMD_SUB) ? svalu_pkg::XW'(a_i) - svalu_pkg::XW'(b_i)
                                          : svalu_pkg::XW'(a_i) + svalu_pkg::XW'(b_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      sum1_q <= sum_d;
      a1_q   <= a_i;
      cmd1_q <= cmd_i;
      prod_q <= x_q * y_q;
      sum2_q <= sum1_q;
      a2_q   <= a1_q;
      cmd2_q <= cmd1_q;
      res_q  <= res_d;
    end
  end

  assign rnd = (prod_q + svalu_pkg::PROD_HALF) >>> svalu_pkg::FRAC_W;

  always_comb begin
    case (cmd2_q)
      svalu_pkg::CMD_ADD,
      svalu_pkg::CMD_SUB:   res_d = svalu_pkg::sat32(svalu_pkg::SAT_W'(sum2_q));
      svalu_pkg::CMD_SCALE: res_d = svalu_pkg::sat32(svalu_pkg::SAT_W'(rnd));
      svalu_pkg::CMD_LERP:  res_d = svalu_pkg::sat32(svalu_pkg::SAT_W'(a2_q)
                                                    + svalu_pkg::SAT_W'(rnd));
      default:              res_d = '0;
    endcase
  end

  assign prod_o = prod_q;
  assign res_o  = res_q;

endmodule

// File: rtl/svalu_isqrt.sv
// ----------------------------------------------------------------------------
// svalu_isqrt
// Pipelined floor square root, one root bit per stage.
// ----------------------------------------------------------------------------
module svalu_isqrt (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic [svalu_pkg::RAD_W-1:0]       rad_i,
  output logic [svalu_pkg::ROOT_W-1:0]      root_o
);

  logic [svalu_pkg::REM_W-1:0]  rem_q  [svalu_pkg::SQ_STAGES-1];
  logic [svalu_pkg::RAD_W-1:0]  rad_q  [svalu_pkg::SQ_STAGES-1];
  logic [svalu_pkg::ROOT_W-1:0] root_q [svalu_pkg::SQ_STAGES];

  for (genvar k = 0; k < svalu_pkg::SQ_STAGES; k++) begin : g_stage
    logic [svalu_pkg::REM_W-1:0]  rem_p, rem_t, trial;
    logic [svalu_pkg::ROOT_W-1:0] root_p;
    logic [svalu_pkg::RAD_W-1:0]  rad_p;
    logic                         take;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = rad_i;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
      assign rad_p  = rad_q[k-1];
    end

    // bring down the next radicand pair, try (root << 2) | 1
    assign rem_t = {rem_p[svalu_pkg::REM_W-3:0], rad_p[svalu_pkg::RAD_W-1 -: 2]};
    assign trial = svalu_pkg::REM_W'({root_p, 2'b01});
    assign take  = (rem_t >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        root_q[k] <= {root_p[svalu_pkg::ROOT_W-2:0], take};
      end
    end

    if (k < svalu_pkg::SQ_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? rem_t - trial : rem_t;
          rad_q[k] <= rad_p << 2;
        end
      end
    end
  end

  assign root_o = root_q[svalu_pkg::SQ_STAGES-1];

endmodule

// File: rtl/svalu_div.sv
// ----------------------------------------------------------------------------
// svalu_div
// Pipelined restoring divider for one normalize lane, rounded half away
// from zero: (|a| * 2^16 + m/2) / m, one quotient bit per stage.
// ----------------------------------------------------------------------------
module svalu_div (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  svalu_pkg::word_t              a_i,
  input  logic [svalu_pkg::ROOT_W-1:0]  m_i,
  output svalu_pkg::word_t              q_o,
  output logic [svalu_pkg::ROOT_W-1:0]  m_o
);

  logic [svalu_pkg::DVD_W-1:0]  rem_q [svalu_pkg::DIV_STAGES-1];
  logic [svalu_pkg::Q_W-1:0]    q_q   [svalu_pkg::DIV_STAGES];
  logic [svalu_pkg::ROOT_W-1:0] m_q   [svalu_pkg::DIV_STAGES];
  logic                         neg_q [svalu_pkg::DIV_STAGES];

  logic [svalu_pkg::DATA_W-1:0] mag;
  logic [svalu_pkg::DVD_W-1:0]  dvd;
  svalu_pkg::word_t             qx;

  assign mag = a_i[svalu_pkg::DATA_W-1] ? svalu_pkg::DATA_W'(-a_i) : a_i;
  assign dvd = svalu_pkg::DVD_W'({mag, {svalu_pkg::FRAC_W{1'b0}}})
             + svalu_pkg::DVD_W'(m_i >> 1);

  // |a| never exceeds m, so the quotient fits in Q_W bits
  for (genvar k = 0; k < svalu_pkg::DIV_STAGES; k++) begin : g_stage
    localparam int B = svalu_pkg::Q_W - 1 - k;
    logic [svalu_pkg::DVD_W-1:0]  rem_p, dsh;
    logic [svalu_pkg::Q_W-1:0]    q_p;
    logic [svalu_pkg::ROOT_W-1:0] m_p;
    logic                         neg_p, take;

    if (k == 0) begin : g_first
      assign rem_p = dvd;
      assign q_p   = '0;
      assign m_p   = m_i;
      assign neg_p = a_i[svalu_pkg::DATA_W-1];
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign q_p   = q_q[k-1];
      assign m_p   = m_q[k-1];
      assign neg_p = neg_q[k-1];
    end

    assign dsh  = svalu_pkg::DVD_W'(m_p) << B;
    assign take = (rem_p >= dsh);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        q_q[k]   <= q_p | (svalu_pkg::Q_W'(take) << B);
        m_q[k]   <= m_p;
        neg_q[k] <= neg_p;
      end
    end

    if (k < svalu_pkg::DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[k] <= take ? rem_p - dsh : rem_p;
        end
      end
    end
  end

  assign qx  = svalu_pkg::word_t'(svalu_pkg::DATA_W'(q_q[svalu_pkg::DIV_STAGES-1]));
  assign q_o = neg_q[svalu_pkg::DIV_STAGES-1] ? -qx : qx;
  assign m_o = m_q[svalu_pkg::DIV_STAGES-1];

endmodule

// File: rtl/svalu_outq.sv
// ----------------------------------------------------------------------------
// svalu_outq
// Two-entry result queue; decouples the pipeline from the result sink.
// ----------------------------------------------------------------------------
module svalu_outq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  svalu_pkg::out_t     data_i,
  output logic                full_o,
  svalu_out_if.source         out_o
);

  svalu_pkg::out_t ent_q [2];
  logic            wr_q, rd_q;
  logic [1:0]      cnt_q;
  logic            pop;
  svalu_pkg::out_t head;

  assign pop    = out_o.valid && out_o.ready;
  assign full_o = (cnt_q == 2'd2);
  assign head   = ent_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop)    rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) ent_q[wr_q] <= data_i;
  end

  assign out_o.valid      = (cnt_q != 2'd0);
  assign out_o.out_0      = head.v[0];
  assign out_o.out_1      = head.v[1];
  assign out_o.out_2      = head.v[2];
  assign out_o.out_3      = head.v[3];
  assign out_o.scalar_out = head.sc;
  assign out_o.saturated  = head.flag;

endmodule
